### design/slu_pkg.sv
package slu_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_LEAD    = 3'd1,
    ERR_BAD_CONT    = 3'd2,
    ERR_UNKNOWN_ESC = 3'd3,
    ERR_BAD_HEX     = 3'd4,
    ERR_HEX_RANGE   = 3'd5,
    ERR_SURROGATE   = 3'd6,
    ERR_TRUNCATED   = 3'd7
  } slu_err_e;

  // One classified input transaction, as handed from front to back.
  // n_data = 1 carries a raw byte or a code point below 0x80 in data[7:0];
  // n_data = 2..4 carries a code point to be UTF-8 encoded.
  typedef struct packed {
    logic [20:0] data;
    logic [2:0]  n_data;
    slu_err_e    err;
    logic        eos;
  } slu_cmd_t;

  // {hit, byte} for the single-character escapes
  function automatic logic [8:0] esc_lookup(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h27:   r = {1'b1, 8'h27}; // '
      8'h22:   r = {1'b1, 8'h22}; // "
      8'h5C:   r = {1'b1, 8'h5C}; // backslash
      8'h24:   r = {1'b1, 8'h24}; // $
      8'h30:   r = {1'b1, 8'h00}; // 0
      8'h61:   r = {1'b1, 8'h07}; // a
      8'h62:   r = {1'b1, 8'h08}; // b
      8'h66:   r = {1'b1, 8'h0C}; // f
      8'h6E:   r = {1'b1, 8'h0A}; // n
      8'h72:   r = {1'b1, 8'h0D}; // r
      8'h74:   r = {1'b1, 8'h09}; // t
      8'h76:   r = {1'b1, 8'h0B}; // v
      default: r = 9'h000;
    endcase
    return r;
  endfunction

  // {ok, nibble}
  function automatic logic [4:0] hex_lookup(logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Byte k of an n-byte UTF-8 encoding of cp.
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] n, logic [1:0] k);
    logic [7:0] r;
    r = cp[7:0];
    case (n)
      3'd2: begin
        case (k)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (k)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (k)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: r = cp[7:0];
    endcase
    return r;
  endfunction

endpackage

### design/slu_if.sv
interface slu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface slu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] error_code;
  logic       run_last;
  logic       string_done;

  modport source (output valid, out_byte, byte_valid, error_code, run_last, string_done,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, error_code, run_last, string_done,
                  output ready);
endinterface

### design/slu_front.sv
module slu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_string_i,
  input  logic              full_i,
  output logic              push_o,
  output slu_pkg::slu_cmd_t cmd_o
);
  import slu_pkg::*;

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_HEX   = 2'd2;
  localparam logic [1:0] PH_CONT  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [23:0] hex_q, hex_d;
  logic [2:0]  digits_q, digits_d;
  logic        uni_q, uni_d;
  logic [1:0]  cont_q, cont_d;
  logic        err_seen_q, err_seen_d;
  logic        esc_en_q;

  logic        fire;
  logic [8:0]  esc;
  logic [4:0]  hx;
  logic [23:0] hex_new;
  logic [2:0]  digits_m1;
  logic [1:0]  cont_m1;
  slu_err_e    err;
  logic [2:0]  n_data;
  logic [20:0] data;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && !full_i;
  assign esc        = esc_lookup(in_byte_i);
  assign hx         = hex_lookup(in_byte_i);
  assign hex_new    = {hex_q[19:0], hx[3:0]};
  assign digits_m1  = digits_q - 3'd1;
  assign cont_m1    = cont_q - 2'd1;

  always_comb begin
    phase_d    = phase_q;
    hex_d      = hex_q;
    digits_d   = digits_q;
    uni_d      = uni_q;
    cont_d     = cont_q;
    err_seen_d = err_seen_q;
    err        = ERR_NONE;
    n_data     = 3'd0;
    data       = {13'd0, in_byte_i};

    if (!err_seen_q) begin
      case (phase_q)
        PH_PLAIN: begin
          if (!in_byte_i[7]) begin
            if (in_byte_i == 8'h5C && esc_en_q) begin
              phase_d = PH_ESC;
            end else begin
              n_data = 3'd1;
            end
          end else if (in_byte_i inside {[8'hC0:8'hF7]}) begin
            n_data  = 3'd1;
            phase_d = PH_CONT;
            if (in_byte_i[7:5] == 3'b110) begin
              cont_d = 2'd1;
            end else if (in_byte_i[7:4] == 4'b1110) begin
              cont_d = 2'd2;
            end else begin
              cont_d = 2'd3;
            end
          end else begin
            err = ERR_BAD_LEAD;
          end
        end
        PH_CONT: begin
          if (in_byte_i[7:6] == 2'b10) begin
            n_data = 3'd1;
            cont_d = cont_m1;
            if (cont_m1 == 2'd0) phase_d = PH_PLAIN;
          end else begin
            err = ERR_BAD_CONT;
          end
        end
        PH_ESC: begin
          if (esc[8]) begin
            n_data  = 3'd1;
            data    = {13'd0, esc[7:0]};
            phase_d = PH_PLAIN;
          end else if (in_byte_i == 8'h78 || in_byte_i == 8'h75) begin
            uni_d    = (in_byte_i == 8'h75);
            digits_d = (in_byte_i == 8'h75) ? 3'd6 : 3'd2;
            hex_d    = 24'd0;
            phase_d  = PH_HEX;
          end else begin
            err = ERR_UNKNOWN_ESC;
          end
        end
        default: begin
          if (!hx[4]) begin
            err = ERR_BAD_HEX;
          end else begin
            hex_d    = hex_new;
            digits_d = digits_m1;
            if (digits_m1 == 3'd0) begin
              phase_d = PH_PLAIN;
              if (hex_new > (uni_q ? 24'h10FFFF : 24'h00007F)) begin
                err = ERR_HEX_RANGE;
              end else if (hex_new >= 24'h00D800 && hex_new <= 24'h00DFFF) begin
                err = ERR_SURROGATE;
              end else begin
                data = hex_new[20:0];
                if (hex_new <= 24'h00007F)      n_data = 3'd1;
                else if (hex_new <= 24'h0007FF) n_data = 3'd2;
                else if (hex_new <= 24'h00FFFF) n_data = 3'd3;
                else                            n_data = 3'd4;
              end
            end
          end
        end
      endcase
      if (err != ERR_NONE) err_seen_d = 1'b1;
    end

    if (end_of_string_i) begin
      if (!err_seen_d && phase_d != PH_PLAIN) err = ERR_TRUNCATED;
      phase_d    = PH_PLAIN;
      hex_d      = 24'd0;
      digits_d   = 3'd0;
      uni_d      = 1'b0;
      cont_d     = 2'd0;
      err_seen_d = 1'b0;
    end
  end

  assign cmd_o.data   = data;
  assign cmd_o.n_data = n_data;
  assign cmd_o.err    = err;
  assign cmd_o.eos    = end_of_string_i;
  // dropped bytes and a bare backslash produce nothing
  assign push_o = fire && (n_data != 3'd0 || err != ERR_NONE || end_of_string_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PLAIN;
      hex_q      <= 24'd0;
      digits_q   <= 3'd0;
      uni_q      <= 1'b0;
      cont_q     <= 2'd0;
      err_seen_q <= 1'b0;
    end else if (fire) begin
      phase_q    <= phase_d;
      hex_q      <= hex_d;
      digits_q   <= digits_d;
      uni_q      <= uni_d;
      cont_q     <= cont_d;
      err_seen_q <= err_seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      esc_en_q <= cfg_wdata_i;
    end
  end

endmodule

### design/slu_fifo.sv
module slu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slu_pkg::slu_cmd_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output slu_pkg::slu_cmd_t rdata_o,
  output logic              empty_o
);
  import slu_pkg::*;

  localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] DEPTH_CNT = FIFO_CNT_W'(FIFO_DEPTH);

  slu_cmd_t                entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;
  logic                    do_push, do_pop;

  assign full_o  = (count_q == DEPTH_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### design/slu_back.sv
module slu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slu_pkg::slu_cmd_t cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic [2:0]        error_code_o,
  output logic              run_last_o,
  output logic              string_done_o
);
  import slu_pkg::*;

  logic [1:0] idx_q;
  logic [2:0] total;
  logic       has_err, is_empty, last, load;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       obv_q, olast_q, odone_q;
  logic [2:0] oerr_q;

  assign has_err  = (cmd_i.err != ERR_NONE);
  assign is_empty = cmd_i.eos && cmd_i.n_data == 3'd0 && !has_err;
  assign total    = cmd_i.n_data + {2'b00, has_err} + {2'b00, is_empty};
  assign last     = ({1'b0, idx_q} + 3'd1 == total);
  assign load     = !empty_i && (!ovalid_q || out_ready_i);
  assign pop_o    = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= 2'd0;
    end else if (load) begin
      ovalid_q <= 1'b1;
      idx_q    <= last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if ({1'b0, idx_q} < cmd_i.n_data) begin
        obyte_q <= utf8_byte(cmd_i.data, cmd_i.n_data, idx_q);
        obv_q   <= 1'b1;
        oerr_q  <= ERR_NONE;
      end else begin
        obyte_q <= 8'd0;
        obv_q   <= 1'b0;
        oerr_q  <= cmd_i.err;
      end
      olast_q <= last;
      odone_q <= last && cmd_i.eos;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_byte_o    = obyte_q;
  assign byte_valid_o  = obv_q;
  assign error_code_o  = oerr_q;
  assign run_last_o    = olast_q;
  assign string_done_o = odone_q;

endmodule

### design/string_literal_unescaper_unit.sv
// Channel  Dir  Fields                                                 Handshake
// in_i     in   in_byte[7:0], end_of_string                            valid/ready
// out_o    out  out_byte[7:0], byte_valid, error_code[2:0],            valid/ready
//               run_last, string_done
// cfg      in   cfg_wdata_i (escape enable)                            cfg_we_i
//
// Input takes one byte per cycle while the command queue has room; the
// front classifies each byte in the cycle it is accepted.
// Output gives one result per cycle while out_o is ready; a \u escape yields up
// to four results from one command, so the back end owns the rate for those.
// Output is registered: an accepted byte passes through the command queue and
// then the output register before its first result can be taken (later if
// older commands are queued).
// Reset is asynchronous, active low; escape enable resets to 1. No sweep.
// Either side can stall independently; the queue holds four commands.
module string_literal_unescaper_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  slu_in_if.sink    in_i,
  slu_out_if.source out_o
);
  import slu_pkg::*;

  // front -> queue
  slu_cmd_t push_cmd;
  logic     push;
  logic     full;
  // queue -> back
  slu_cmd_t head_cmd;
  logic     empty;
  logic     pop;

  // Front: parse state machine, escape tables, hex accumulation, range checks.
  // Emits one command per transaction that produces any result.
  slu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_byte_i       (in_i.in_byte),
    .end_of_string_i (in_i.end_of_string),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Short queue decoupling the byte-rate front from the multi-result back.
  slu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (empty)
  );

  // Back: expands a command into its results (UTF-8 bytes, error, or the
  // empty end marker) into the output register, one per cycle unless stalled.
  slu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .byte_valid_o  (out_o.byte_valid),
    .error_code_o  (out_o.error_code),
    .run_last_o    (out_o.run_last),
    .string_done_o (out_o.string_done)
  );

endmodule
